### design/assert_macros.svh
// Assertion helpers used by the checker file.
// Both macros expect signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/sic_pkg.sv
package sic_pkg;

    // Cache geometry
    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths
    localparam int SIZE_W   = 10;
    localparam int SMOOTH_W = 2;
    localparam int INDEX_W  = 3;

    // Smoothing request codes; code three is treated like SMOOTH_ANY
    localparam logic [SMOOTH_W-1:0] SMOOTH_OFF = 2'd0;
    localparam logic [SMOOTH_W-1:0] SMOOTH_ON  = 2'd1;
    localparam logic [SMOOTH_W-1:0] SMOOTH_ANY = 2'd2;

    // Slot number to the fixed-width result field (masked or zero extended)
    function automatic logic [INDEX_W-1:0] to_index(input logic [SLOT_W-1:0] slot);
        logic [31:0] wide;
        wide = 32'(slot);
        return wide[INDEX_W-1:0];
    endfunction

endpackage

### design/size_instance_cache_unit.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   point_size, smooth_request
// rsp      out        rsp_valid/rsp_stall   slot_index, hit, free_previous
//
// One request per cycle while req_stall is low. A request beat is registered in the
// input register when it is taken, and its result is loaded into the result register when it advances.
// The lookup and victim pick are combinational between the input register and the
// result register, and the slot table updates as the result loads, so each update is seen by the next.
// rst_n clears the slot table at once: all slots empty, ages equal to slot index.
// A stalled result holds; the input register takes one more beat, then req_stall rises.
module size_instance_cache_unit
    import sic_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [SIZE_W-1:0]   point_size,
    input  logic [SMOOTH_W-1:0] smooth_request,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [INDEX_W-1:0]  slot_index,
    output logic                hit,
    output logic                free_previous
);

    // Input register
    logic                in_valid_reg, in_valid_next;
    logic [SIZE_W-1:0]   in_size_reg;
    logic [SMOOTH_W-1:0] in_smooth_reg;

    // Slot table
    logic [SIZE_W-1:0]   size_reg   [SLOTS];
    logic [SMOOTH_W-1:0] smooth_reg [SLOTS];
    logic [SLOT_W-1:0]   age_reg    [SLOTS];
    logic [SLOTS-1:0]    filled_reg;

    // Result register
    logic               rsp_valid_reg, rsp_valid_next;
    logic [INDEX_W-1:0] slot_index_reg;
    logic               hit_reg;
    logic               free_previous_reg;

    logic              advance;
    logic              req_take;
    logic              any_smooth;
    logic [SLOTS-1:0]  match;
    logic              found;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] victim;
    logic [SMOOTH_W-1:0] store_smooth;

    // Handshake control
    assign advance   = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    // Parallel tag compare
    assign any_smooth = in_smooth_reg[1];

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i] = filled_reg[i] && (size_reg[i] == in_size_reg) &&
                       (any_smooth || (smooth_reg[i] == in_smooth_reg));
        end
    end

    // Lowest matching slot wins
    always_comb
    begin
        hit_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match[i])
                hit_slot = SLOT_W'(i);
        end
    end

    assign found = |match;

    // Victim: lowest slot with age zero, slot 0 if none
    always_comb
    begin
        victim = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (age_reg[i] == '0)
                victim = SLOT_W'(i);
        end
    end

    // Don't-care misses are stored as smoothed
    assign store_smooth = any_smooth ? SMOOTH_ON : in_smooth_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_size_reg   <= point_size;
            in_smooth_reg <= smooth_request;
        end
    end

    // Slot table update on a miss
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                size_reg[i]   <= '0;
                smooth_reg[i] <= SMOOTH_ANY;
                age_reg[i]    <= SLOT_W'(i);
            end
            filled_reg <= '0;
        end
        else if (advance && !found)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (SLOT_W'(i) == victim)
                begin
                    age_reg[i]    <= SLOT_W'(SLOTS - 1);
                    size_reg[i]   <= in_size_reg;
                    smooth_reg[i] <= store_smooth;
                    filled_reg[i] <= 1'b1;
                end
                else if (age_reg[i] != '0)
                begin
                    age_reg[i] <= age_reg[i] - 1'b1;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot_index_reg    <= to_index(found ? hit_slot : victim);
            hit_reg           <= found;
            free_previous_reg <= !found && filled_reg[victim];
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign slot_index    = slot_index_reg;
    assign hit           = hit_reg;
    assign free_previous = free_previous_reg;

endmodule

### design/sic_checker.sv
`include "assert_macros.svh"

module sic_checker
    import sic_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input logic [INDEX_W-1:0]  slot_index,
    input logic                hit,
    input logic                free_previous
);

    localparam int CNT_W = SLOT_W + 1;

    logic              rsp_beat;
    logic              miss_beat;
    logic              req_beat;
    logic [SLOT_W-1:0] last_miss_reg, expect_slot;
    logic [CNT_W-1:0]  miss_count_reg;
    logic              table_full;

    assign rsp_beat  = rsp_valid && !rsp_stall;
    assign miss_beat = rsp_beat && !hit;
    assign req_beat  = req_valid && !req_stall;

    // Replacement is FIFO: misses fill slots in rotation
    assign expect_slot = (last_miss_reg == SLOT_W'(SLOTS - 1)) ? '0 : last_miss_reg + 1'b1;
    assign table_full  = miss_count_reg >= CNT_W'(SLOTS);

    // Track delivered misses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_miss_reg  <= SLOT_W'(SLOTS - 1);
            miss_count_reg <= '0;
        end
        else if (miss_beat)
        begin
            last_miss_reg <= expect_slot;
            if (!table_full)
                miss_count_reg <= miss_count_reg + 1'b1;
        end
    end

    `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(slot_index) && $stable(hit) && $stable(free_previous))
    `ASSERT_SAME(a_hit_no_free, rsp_valid && hit, !free_previous)
    `ASSERT_SAME(a_fifo_slot, miss_beat, slot_index == to_index(expect_slot))
    `ASSERT_SAME(a_free_when_full, miss_beat, free_previous == table_full)
    `ASSERT_NEXT(a_no_rsp_without_req, !rsp_valid && !$past(req_beat), !rsp_valid)

endmodule

bind size_instance_cache_unit sic_checker u_sic_checker (.*);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import sic_pkg::*;

    // Smoothing code three behaves like SMOOTH_ANY
    localparam logic [SMOOTH_W-1:0] SMOOTH_ANY_ALT = 2'd3;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_COUNT = 1035;
    localparam int POOL_DEPTH   = 12;

    typedef struct packed {
        logic [INDEX_W-1:0] slot;
        logic               hit;
        logic               freed;
    } slot_result_t;

    typedef struct {
        logic [SIZE_W-1:0]   size;
        logic [SMOOTH_W-1:0] smooth;
        bit                  known;
        slot_result_t        want;
    } probe_row_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [SIZE_W-1:0]   point_size;
    logic [SMOOTH_W-1:0] smooth_request;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [INDEX_W-1:0]  slot_index;
    logic                hit;
    logic                free_previous;

    // Shadow copy of the slot table
    logic [SIZE_W-1:0]   shadow_size [SLOTS];
    logic [SMOOTH_W-1:0] shadow_smooth [SLOTS];
    logic [SLOT_W-1:0]   shadow_age [SLOTS];
    logic                shadow_filled [SLOTS];

    slot_result_t pending_slots[$];

    int  error_count;
    int  cycle_count;
    int  hits_seen;
    int  fills_seen;
    int  evictions_seen;
    int  stall_left;
    bit  calm_phase;

    probe_row_t        probe_rows[16];
    logic [SIZE_W-1:0] size_pool[POOL_DEPTH];

    size_instance_cache_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .point_size     (point_size),
        .smooth_request (smooth_request),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .slot_index     (slot_index),
        .hit            (hit),
        .free_previous  (free_previous)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Lookup against the shadow table; a miss updates it FIFO style
    function automatic slot_result_t predict_lookup(input logic [SIZE_W-1:0] size,
                                                    input logic [SMOOTH_W-1:0] sm);
        slot_result_t res;
        logic         any_smooth;
        bit           found;
        int           victim;
        res        = '0;
        found      = 1'b0;
        victim     = 0;
        any_smooth = (sm == SMOOTH_ANY) || (sm == SMOOTH_ANY_ALT);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!found && shadow_filled[i] && shadow_size[i] == size &&
                (any_smooth || shadow_smooth[i] == sm))
            begin
                found     = 1'b1;
                res.slot  = INDEX_W'(i);
                res.hit   = 1'b1;
            end
        end
        if (found)
            return res;
        // victim is the oldest slot (age zero); slot 0 if none
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!found && shadow_age[i] == '0)
            begin
                found  = 1'b1;
                victim = i;
            end
        end
        res.slot  = INDEX_W'(victim);
        res.hit   = 1'b0;
        res.freed = shadow_filled[victim];
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_age[i] != '0)
                shadow_age[i] = shadow_age[i] - 1'b1;
        end
        shadow_age[victim]    = SLOT_W'(SLOTS - 1);
        shadow_size[victim]   = size;
        shadow_smooth[victim] = any_smooth ? SMOOTH_ON : sm;
        shadow_filled[victim] = 1'b1;
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Send one request beat; expectation is queued when it is taken
    task automatic issue_request(input logic [SIZE_W-1:0] size,
                                 input logic [SMOOTH_W-1:0] sm,
                                 input bit known,
                                 input slot_result_t want);
        int           gap;
        slot_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid      <= 1'b1;
        point_size     <= size;
        smooth_request <= sm;
        do
            @(posedge clk);
        while (req_stall);
        predicted = predict_lookup(size, sm);
        pending_slots.push_back(known ? want : predicted);
    endtask

    task automatic wait_for_drain();
        while (pending_slots.size() != 0)
            @(posedge clk);
    endtask

    // Cycle limit and quiet-phase switching
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 299)
            calm_phase <= ($urandom_range(0, 3) == 0);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result-side backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp_stall  <= 1'b1;
            end
            else
            begin
                int len;
                len = pick_gap();
                rsp_stall  <= (len > 0);
                stall_left <= (len > 0) ? len - 1 : 0;
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_slots.size() == 0)
            begin
                $error("unexpected result beat: slot_index %0d hit %0d free_previous %0d",
                       slot_index, hit, free_previous);
                error_count++;
            end
            else
            begin
                slot_result_t exp_res;
                exp_res = pending_slots.pop_front();
                if (slot_index !== exp_res.slot)
                begin
                    $error("slot_index: expected %0d, got %0d", exp_res.slot, slot_index);
                    error_count++;
                end
                if (hit !== exp_res.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp_res.hit, hit);
                    error_count++;
                end
                if (free_previous !== exp_res.freed)
                begin
                    $error("free_previous: expected %0d, got %0d",
                           exp_res.freed, free_previous);
                    error_count++;
                end
                if (exp_res.hit)
                    hits_seen++;
                else
                    fills_seen++;
                if (exp_res.freed)
                    evictions_seen++;
            end
        end
    end

    initial
    begin
        logic [SIZE_W-1:0]   size;
        logic [SMOOTH_W-1:0] sm;
        int                  pick;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        point_size     = '0;
        smooth_request = SMOOTH_OFF;
        rsp_stall      = 1'b0;
        stall_left     = 0;
        calm_phase     = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        hits_seen      = 0;
        fills_seen     = 0;
        evictions_seen = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_size[i]   = '0;
            shadow_smooth[i] = SMOOTH_ANY;
            shadow_age[i]    = SLOT_W'(i);
            shadow_filled[i] = 1'b0;
        end

        // size, smoothing, typed-in flag, {slot, hit, free}
        probe_rows = '{
            // first fills after reset go to slots in order
            '{10'd1,    SMOOTH_OFF,     1'b1, '{3'd0, 1'b0, 1'b0}},
            '{10'd1023, SMOOTH_ON,      1'b1, '{3'd1, 1'b0, 1'b0}},
            '{10'd1,    SMOOTH_ON,      1'b0, '0},
            // don't care hits the lowest matching slot
            '{10'd1,    SMOOTH_ANY,     1'b1, '{3'd0, 1'b1, 1'b0}},
            '{10'd1023, SMOOTH_OFF,     1'b0, '0},
            // size zero is stored like any other
            '{10'd0,    SMOOTH_OFF,     1'b0, '0},
            '{10'd0,    SMOOTH_OFF,     1'b0, '0},
            // don't-care miss is stored as smoothed
            '{10'd512,  SMOOTH_ANY,     1'b0, '0},
            '{10'd512,  SMOOTH_ON,      1'b0, '0},
            '{10'd512,  SMOOTH_OFF,     1'b0, '0},
            '{10'd341,  SMOOTH_ANY_ALT, 1'b0, '0},
            '{10'd341,  SMOOTH_ON,      1'b0, '0},
            // table full: evictions start
            '{10'd682,  SMOOTH_OFF,     1'b0, '0},
            '{10'd1,    SMOOTH_OFF,     1'b0, '0},
            '{10'd1023, SMOOTH_ANY_ALT, 1'b0, '0},
            '{10'd682,  SMOOTH_ANY_ALT, 1'b0, '0}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        foreach (probe_rows[i])
            issue_request(probe_rows[i].size, probe_rows[i].smooth,
                          probe_rows[i].known, probe_rows[i].want);
        @(negedge clk);
        req_valid <= 1'b0;
        wait_for_drain();

        // random part: a small working set of sizes so hits and evictions mix
        foreach (size_pool[i])
            size_pool[i] = SIZE_W'($urandom_range(1, 1023));
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                size_pool[$urandom_range(0, POOL_DEPTH - 1)] = SIZE_W'($urandom_range(1, 1023));
            pick = $urandom_range(0, 99);
            if (pick < 80)
                size = size_pool[$urandom_range(0, POOL_DEPTH - 1)];
            else if (pick < 95)
                size = SIZE_W'($urandom_range(1, 1023));
            else if (pick < 98)
                size = '0;
            else
                size = '1;
            sm = SMOOTH_W'($urandom_range(0, 3));
            issue_request(size, sm, 1'b0, '0);
            // hold off once mid-run until the result side is empty
            if (n == RANDOM_COUNT / 2)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                wait_for_drain();
            end
        end
        @(negedge clk);
        req_valid <= 1'b0;
        wait_for_drain();
        repeat (10) @(posedge clk);

        $display("Covered %0d directed and %0d random requests under random gaps and stalls",
                 $size(probe_rows), RANDOM_COUNT);
        $display("Results: %0d hits, %0d fills, %0d of them evicting a filled slot",
                 hits_seen, fills_seen, evictions_seen);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
